// ----- hw/rtl/spq_pkg.sv -----
// Shared types, sizes and codes for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int CAPACITY       = 16;
	localparam int ID_WIDTH       = 16;
	localparam int PRIORITY_WIDTH = 8;
	localparam int OP_WIDTH       = 2;
	localparam int STATUS_WIDTH   = 3;

	localparam int IN_BITS   = OP_WIDTH + ID_WIDTH + PRIORITY_WIDTH;
	localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = STATUS_WIDTH + ID_WIDTH + PRIORITY_WIDTH;
	localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [OP_WIDTH-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_WIDTH-1:0] OP_POP    = 2'd1;
	localparam logic [OP_WIDTH-1:0] OP_REMOVE = 2'd2;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_ADDED     = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_POPPED    = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_NOT_FOUND = 3'd5,
		ST_FULL      = 3'd6
	} status_t;

	// Contents of one slot of the chain.
	typedef struct packed {
		logic                      valid;
		logic [ID_WIDTH-1:0]       id;
		logic [PRIORITY_WIDTH-1:0] pri;
	} slot_t;

	// Command broadcast to every cell for an update.
	typedef struct packed {
		logic                      ins;
		logic                      del;
		logic [ID_WIDTH-1:0]       id;
		logic [PRIORITY_WIDTH-1:0] pri;
	} cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stable_priority_queue_with_remove.sv -----
// Top level of the stable priority queue: command register, cell chain and result register.
//
// Channel  Dir  Fields (lowest bit up)
// s_axis   in   operation[1:0], entry_id[17:2], priority_req[25:18], zero pad to 32
// m_axis   out  status[2:0], result_id[18:3], result_priority[26:19], zero pad to 32
//
// For each command the beat is registered, then the whole chain compares in
// parallel and shifts while the result is registered.
// A new beat is taken once the previous command has updated the chain.
// A result waiting on m_axis stalls the update of the next command only.
// Reset clears all occupancy bits at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_with_remove (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// operation, entry_id, priority_req, zero pad
	input  wire  [spq_pkg::IN_TDATA-1:0]     s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// status, result_id, result_priority, zero pad
	output logic [spq_pkg::OUT_TDATA-1:0]    m_axis_tdata
);

	localparam int CAP = spq_pkg::CAPACITY;
	localparam int IDW = spq_pkg::ID_WIDTH;
	localparam int PW  = spq_pkg::PRIORITY_WIDTH;
	localparam int OW  = spq_pkg::OP_WIDTH;

	logic                busy_q;
	logic [OW-1:0]       req_op_q;
	logic [IDW-1:0]      req_id_q;
	logic [PW-1:0]       req_pri_q;
	logic                out_valid_q;
	spq_pkg::status_t    out_status_q;
	logic [IDW-1:0]      out_id_q;
	logic [PW-1:0]       out_pri_q;

	spq_pkg::cmd_t       cmd;
	spq_pkg::slot_t      slots [CAP];
	logic [CAP-1:0]      ge_v;
	logic [CAP-1:0]      found_v;
	logic [CAP-1:0]      valid_v;
	logic                fire;
	logic                in_fire;
	logic                full;
	logic                empty;
	logic                found;
	logic                is_add;
	logic                is_pop;
	logic                is_remove;
	spq_pkg::status_t    status_d;
	logic [IDW-1:0]      rid_d;
	logic [PW-1:0]       rpri_d;

	assign s_axis_tready = !busy_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign fire          = busy_q && (!out_valid_q || m_axis_tready);

	assign is_add    = (req_op_q == spq_pkg::OP_ADD);
	assign is_pop    = (req_op_q == spq_pkg::OP_POP);
	assign is_remove = (req_op_q == spq_pkg::OP_REMOVE);

	assign full  = slots[CAP-1].valid;
	assign empty = !slots[0].valid;
	// With a pop the found chain is seeded at the head, so it is only a
	// duplicate or match flag for add and remove.
	assign found = found_v[CAP-1];

	assign cmd.ins = fire && is_add && !found && !full;
	assign cmd.del = fire && ((is_pop && !empty) || is_remove);
	assign cmd.id  = req_id_q;
	assign cmd.pri = req_pri_q;

	genvar gi;
	generate
		for (gi = 0; gi < CAP; gi++) begin : g_cell
			spq_pkg::slot_t left_s;
			spq_pkg::slot_t right_s;
			logic           left_ge_s;
			logic           found_in_s;

			if (gi == 0) begin : g_head
				assign left_s     = '0;
				assign left_ge_s  = 1'b1;
				assign found_in_s = is_pop;
			end else begin : g_body
				assign left_s     = slots[gi-1];
				assign left_ge_s  = ge_v[gi-1];
				assign found_in_s = found_v[gi-1];
			end

			if (gi == CAP - 1) begin : g_tail
				assign right_s = '0;
			end else begin : g_inner
				assign right_s = slots[gi+1];
			end

			spq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.left      (left_s),
				.left_ge   (left_ge_s),
				.right     (right_s),
				.found_in  (found_in_s),
				.slot      (slots[gi]),
				.ge        (ge_v[gi]),
				.found_out (found_v[gi])
			);

			assign valid_v[gi] = slots[gi].valid;
		end
	endgenerate

	always_comb begin
		rid_d  = req_id_q;
		rpri_d = '0;
		case (req_op_q)
			spq_pkg::OP_ADD: begin
				if (found) begin
					status_d = spq_pkg::ST_DUPLICATE;
				end else if (full) begin
					status_d = spq_pkg::ST_FULL;
				end else begin
					status_d = spq_pkg::ST_ADDED;
				end
			end
			spq_pkg::OP_POP: begin
				if (empty) begin
					status_d = spq_pkg::ST_EMPTY;
					rid_d    = '0;
				end else begin
					status_d = spq_pkg::ST_POPPED;
					rid_d    = slots[0].id;
					rpri_d   = slots[0].pri;
				end
			end
			spq_pkg::OP_REMOVE: begin
				status_d = found ? spq_pkg::ST_REMOVED : spq_pkg::ST_NOT_FOUND;
			end
			default: begin
				status_d = spq_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_op_q  <= s_axis_tdata[OW-1:0];
			req_id_q  <= s_axis_tdata[OW+IDW-1:OW];
			req_pri_q <= s_axis_tdata[OW+IDW+PW-1:OW+IDW];
		end
		if (fire) begin
			out_status_q <= status_d;
			out_id_q     <= rid_d;
			out_pri_q    <= rpri_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(spq_pkg::OUT_TDATA - spq_pkg::OUT_BITS){1'b0}},
		out_pri_q, out_id_q, out_status_q};

`ifndef ASSERT_OFF
	// Occupied slots always form a prefix starting at the head.
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, valid_v} + {{CAP{1'b0}}, 1'b1}) & {1'b0, valid_v}) == '0)
		else $error("occupied slots are not a prefix");

	// An insert grows the occupancy by exactly one.
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> $countones(valid_v) == $past($countones(valid_v)) + 1)
		else $error("insert did not add exactly one entry");

	// A delete that finds its target shrinks the occupancy by exactly one.
	a_del_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.del && found) |=> $countones(valid_v) == $past($countones(valid_v)) - 1)
		else $error("delete did not remove exactly one entry");

	// Every chain update produces a result beat on the next cycle.
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_axis_tvalid && !busy_q)
		else $error("update without a result beat");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// One slot of the queue chain: compares against the request and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
	input  wire               clk,
	input  wire               arst_n,
	input  spq_pkg::cmd_t     cmd,
	input  spq_pkg::slot_t    left,
	input  wire               left_ge,
	input  spq_pkg::slot_t    right,
	input  wire               found_in,
	output spq_pkg::slot_t    slot,
	output logic              ge,
	output logic              found_out
);

	logic                               valid_q;
	logic [spq_pkg::ID_WIDTH-1:0]       id_q;
	logic [spq_pkg::PRIORITY_WIDTH-1:0] pri_q;
	logic                               match;
	logic                               take_new;
	logic                               take_left;
	logic                               take_right;

	assign ge        = valid_q && (pri_q >= cmd.pri);
	assign match     = valid_q && (id_q == cmd.id);
	assign found_out = found_in | match;

	assign take_new   = cmd.ins && !ge && left_ge;
	assign take_left  = cmd.ins && !ge && !left_ge;
	assign take_right = cmd.del && found_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_left) begin
			valid_q <= left.valid;
		end else if (take_right) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			id_q  <= cmd.id;
			pri_q <= cmd.pri;
		end else if (take_left) begin
			id_q  <= left.id;
			pri_q <= left.pri;
		end else if (take_right) begin
			id_q  <= right.id;
			pri_q <= right.pri;
		end
	end

	assign slot = {valid_q, id_q, pri_q};

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the stable priority queue with removal by identifier.
`timescale 1ns / 1ps

module testbench;

	// Operation code 3 has no meaning; the block must answer it as not found.
	localparam logic [spq_pkg::OP_WIDTH-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		spq_pkg::status_t                   status;
		logic [spq_pkg::ID_WIDTH-1:0]       id;
		logic [spq_pkg::PRIORITY_WIDTH-1:0] pri;
	} outcome_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	// operation, entry_id, priority_req, zero pad
	logic [spq_pkg::IN_TDATA-1:0]  s_axis_tdata = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	// status, result_id, result_priority, zero pad
	logic [spq_pkg::OUT_TDATA-1:0] m_axis_tdata;

	// Shadow copy of the store, head at index 0.
	logic [spq_pkg::ID_WIDTH-1:0]       shadow_id [spq_pkg::CAPACITY];
	logic [spq_pkg::PRIORITY_WIDTH-1:0] shadow_pri [spq_pkg::CAPACITY];
	int                                 shadow_count = 0;

	outcome_t expected_outcomes[$];
	int       error_count = 0;
	bit       tx_idle = 1'b0;
	bit       rx_idle = 1'b0;
	int       stall_left = 0;

	stable_priority_queue_with_remove uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 20);
	endfunction

	function automatic int find_slot(logic [spq_pkg::ID_WIDTH-1:0] id);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void delete_slot(int pos);
		for (int i = pos; i + 1 < shadow_count; i++) begin
			shadow_id[i]  = shadow_id[i + 1];
			shadow_pri[i] = shadow_pri[i + 1];
		end
		shadow_count--;
	endfunction

	// Applies one command to the shadow store and returns the status beat it must produce.
	function automatic outcome_t predict_outcome(logic [spq_pkg::OP_WIDTH-1:0] op,
			logic [spq_pkg::ID_WIDTH-1:0] id, logic [spq_pkg::PRIORITY_WIDTH-1:0] pri);
		outcome_t o;
		int       pos;
		int       at;
		o.id  = id;
		o.pri = '0;
		case (op)
			spq_pkg::OP_ADD: begin
				if (find_slot(id) >= 0) begin
					o.status = spq_pkg::ST_DUPLICATE;
				end else if (shadow_count >= spq_pkg::CAPACITY) begin
					o.status = spq_pkg::ST_FULL;
				end else begin
					// A new entry goes behind every entry of equal or higher severity.
					at = 0;
					while (at < shadow_count && shadow_pri[at] >= pri)
						at++;
					for (int i = shadow_count; i > at; i--) begin
						shadow_id[i]  = shadow_id[i - 1];
						shadow_pri[i] = shadow_pri[i - 1];
					end
					shadow_id[at]  = id;
					shadow_pri[at] = pri;
					shadow_count++;
					o.status = spq_pkg::ST_ADDED;
				end
			end
			spq_pkg::OP_POP: begin
				if (shadow_count == 0) begin
					o.status = spq_pkg::ST_EMPTY;
					o.id     = '0;
				end else begin
					o.status = spq_pkg::ST_POPPED;
					o.id     = shadow_id[0];
					o.pri    = shadow_pri[0];
					delete_slot(0);
				end
			end
			spq_pkg::OP_REMOVE: begin
				pos = find_slot(id);
				if (pos < 0) begin
					o.status = spq_pkg::ST_NOT_FOUND;
				end else begin
					o.status = spq_pkg::ST_REMOVED;
					delete_slot(pos);
				end
			end
			default: begin
				o.status = spq_pkg::ST_NOT_FOUND;
			end
		endcase
		return o;
	endfunction

	task automatic send_cmd(logic [spq_pkg::OP_WIDTH-1:0] op,
			logic [spq_pkg::ID_WIDTH-1:0] id, logic [spq_pkg::PRIORITY_WIDTH-1:0] pri);
		int gap;
		gap = tx_idle ? idle_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(spq_pkg::IN_TDATA - spq_pkg::IN_BITS){1'b0}}, pri, id, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_outcomes.push_back(predict_outcome(op, id, pri));
	endtask

	function automatic void check_beat(logic [spq_pkg::OUT_TDATA-1:0] data);
		outcome_t                           want;
		spq_pkg::status_t                   got_status;
		logic [spq_pkg::ID_WIDTH-1:0]       got_id;
		logic [spq_pkg::PRIORITY_WIDTH-1:0] got_pri;
		got_status = spq_pkg::status_t'(data[spq_pkg::STATUS_WIDTH-1:0]);
		got_id     = data[spq_pkg::STATUS_WIDTH +: spq_pkg::ID_WIDTH];
		got_pri    = data[spq_pkg::STATUS_WIDTH + spq_pkg::ID_WIDTH +: spq_pkg::PRIORITY_WIDTH];
		if (expected_outcomes.size() == 0) begin
			$display("%0t: unexpected result beat, actual status %0d id %h priority %h",
				$time, got_status, got_id, got_pri);
			error_count++;
			return;
		end
		want = expected_outcomes.pop_front();
		if (got_status !== want.status) begin
			$display("%0t: status mismatch, expected %0d actual %0d",
				$time, want.status, got_status);
			error_count++;
		end
		if (got_id !== want.id) begin
			$display("%0t: result_id mismatch, expected %h actual %h", $time, want.id, got_id);
			error_count++;
		end
		if (got_pri !== want.pri) begin
			$display("%0t: result_priority mismatch, expected %h actual %h",
				$time, want.pri, got_pri);
			error_count++;
		end
	endfunction

	// Result side: check every accepted beat, then decide whether to stall next cycle.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			check_beat(m_axis_tdata);
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_idle && $urandom_range(0, 99) < 30) begin
			stall_left = idle_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic test_empty_store();
		send_cmd(spq_pkg::OP_POP, 16'h0000, 8'h00);
		send_cmd(spq_pkg::OP_REMOVE, 16'hFFFF, 8'h00);
		send_cmd(OP_UNUSED, 16'hA5A5, 8'hFF);
		send_cmd(spq_pkg::OP_POP, 16'hFFFF, 8'hFF);
	endtask

	// Fills the store with ties and extreme severities, then probes full and duplicate.
	task automatic test_fill_and_full();
		logic [spq_pkg::PRIORITY_WIDTH-1:0] pattern [16];
		logic [spq_pkg::ID_WIDTH-1:0]       id;
		pattern = '{8'd5, 8'd255, 8'd0, 8'd5, 8'd5, 8'd255, 8'd0, 8'd128,
			8'd5, 8'd1, 8'd254, 8'd0, 8'd255, 8'd5, 8'd7, 8'd7};
		for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
			id = (i == 0) ? 16'h0000 : (i == spq_pkg::CAPACITY - 1) ? 16'hFFFF :
				16'h0100 + spq_pkg::ID_WIDTH'(i);
			send_cmd(spq_pkg::OP_ADD, id, pattern[i]);
		end
		send_cmd(spq_pkg::OP_ADD, 16'h0200, 8'd9);
		send_cmd(spq_pkg::OP_ADD, 16'hFFFF, 8'd3);
		send_cmd(spq_pkg::OP_REMOVE, 16'h0105, 8'd0);
		send_cmd(spq_pkg::OP_ADD, 16'h0105, 8'd5);
		send_cmd(spq_pkg::OP_ADD, 16'h0000, 8'd200);
		send_cmd(spq_pkg::OP_POP, 16'h1234, 8'h00);
		send_cmd(spq_pkg::OP_REMOVE, 16'h7777, 8'h00);
	endtask

	// Random commands with weights for add, pop and remove; the rest are unused codes.
	task automatic test_random_traffic(int count, int add_w, int pop_w, int rem_w,
			bit tx_gaps, bit rx_stalls);
		int                                 r;
		logic [spq_pkg::OP_WIDTH-1:0]       op;
		logic [spq_pkg::ID_WIDTH-1:0]       id;
		logic [spq_pkg::PRIORITY_WIDTH-1:0] pri;
		tx_idle = tx_gaps;
		rx_idle = rx_stalls;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < add_w)
				op = spq_pkg::OP_ADD;
			else if (r < add_w + pop_w)
				op = spq_pkg::OP_POP;
			else if (r < add_w + pop_w + rem_w)
				op = spq_pkg::OP_REMOVE;
			else
				op = OP_UNUSED;

			// Identifiers mostly come from a small pool or the store itself so that
			// duplicates and successful removals are common.
			r = $urandom_range(0, 99);
			if (shadow_count > 0 && r < ((op == spq_pkg::OP_REMOVE) ? 65 : 20))
				id = shadow_id[$urandom_range(0, shadow_count - 1)];
			else if (r < 85)
				id = spq_pkg::ID_WIDTH'($urandom_range(0, 63));
			else
				id = spq_pkg::ID_WIDTH'($urandom_range(0, 16'hFFFF));

			r = $urandom_range(0, 99);
			if (r < 40)
				pri = spq_pkg::PRIORITY_WIDTH'($urandom_range(0, 3));
			else if (r < 50)
				pri = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			else
				pri = spq_pkg::PRIORITY_WIDTH'($urandom_range(0, 255));

			send_cmd(op, id, pri);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_fill_and_full();
		test_random_traffic(340, 60, 15, 20, 1'b0, 1'b0);
		test_random_traffic(340, 35, 35, 25, 1'b1, 1'b1);
		test_random_traffic(340, 55, 20, 22, 1'b1, 1'b0);
		test_random_traffic(330, 20, 50, 27, 1'b0, 1'b1);

		s_axis_tvalid <= 1'b0;
		rx_idle = 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (error_count == 0)
			$display("stable_priority_queue_with_remove verification clean");
		else
			$display("stable_priority_queue_with_remove verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("stable_priority_queue_with_remove verification failed");
		$finish;
	end

endmodule
